// ----- design/i2d_pkg.sv -----
package i2d_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned CharW         = 8;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumDabStages  = ValueW / StepsPerStage;
  localparam int unsigned IdxW          = $clog2(NumDigits);

  localparam logic [CharW-1:0]  AsciiZero  = 8'h30;
  localparam logic [CharW-1:0]  AsciiMinus = 8'h2D;
  localparam logic [DigitW-1:0] DabThresh  = 4'd5;
  localparam logic [DigitW-1:0] DabAdjust  = 4'd3;

  typedef logic [NumDigits-1:0][DigitW-1:0] i2d_bcd_t;

  typedef struct packed {
    logic              neg;
    i2d_bcd_t          bcd;
    logic [ValueW-1:0] bin;
  } i2d_dab_t;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic i2d_dab_t dab_step(i2d_dab_t s);
    i2d_bcd_t                         b;
    logic [NumDigits*DigitW+ValueW-1:0] w;
    i2d_dab_t                         r;
    b = s.bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (b[d] >= DabThresh) begin
        b[d] = b[d] + DabAdjust;
      end
    end
    w = {b, s.bin};
    w = {w[NumDigits*DigitW+ValueW-2:0], 1'b0};
    r.neg = s.neg;
    {r.bcd, r.bin} = w;
    return r;
  endfunction

endpackage

// ----- design/i2d_in_if.sv -----
interface i2d_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [i2d_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- design/i2d_out_if.sv -----
interface i2d_out_if;
  logic                       valid;
  logic                       ready;
  logic [i2d_pkg::CharW-1:0]  character;
  logic                       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- design/i2d_dab_stage.sv -----
module i2d_dab_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  i2d_pkg::i2d_dab_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output i2d_pkg::i2d_dab_t data_o
);
  import i2d_pkg::*;

  logic     valid_q;
  i2d_dab_t data_q, data_d;

  // Advance whenever the slot is empty or its request leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_d = dab_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ----- design/i2d_serializer.sv -----
module i2d_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  i2d_pkg::i2d_dab_t data_i,
  i2d_out_if.source         out_o
);
  import i2d_pkg::*;

  logic            busy_q;
  logic            neg_q;
  logic [IdxW-1:0] idx_q;
  i2d_bcd_t        bcd_q;
  logic [IdxW-1:0] lead;
  logic            fire, done, load;

  // Most significant nonzero digit; zero keeps a single digit.
  always_comb begin
    lead = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (data_i.bcd[d] != '0) begin
        lead = IdxW'(d);
      end
    end
  end

  assign out_o.valid     = busy_q;
  assign out_o.character = neg_q ? AsciiMinus : (AsciiZero + {{(CharW-DigitW){1'b0}}, bcd_q[idx_q]});
  assign out_o.last      = !neg_q && (idx_q == '0);

  assign fire    = busy_q && out_o.ready;
  assign done    = fire && out_o.last;
  assign ready_o = !busy_q || done;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= data_i.neg;
      idx_q <= lead;
      bcd_q <= data_i.bcd;
    end else if (fire) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end
endmodule

// ----- design/signed_int_to_decimal_ascii.sv -----
// Converts each 32-bit two's complement request on in_i into its decimal
// text on out_o, one ASCII character per transfer, most significant first,
// with a leading '-' for negative values and last set on the final digit;
// the most negative value gives all eleven characters and zero a single
// '0'. A value passes a magnitude register and four binary to BCD stages of
// eight shift-and-add-3 steps each, then the serializer's register, before
// its first character appears. The single output port then sets the rate:
// one character per cycle while out_o is ready, a value occupying it for
// one character per digit plus one if negative, and the next value's first
// character follows its last with no gap while later values wait in the stages.
module signed_int_to_decimal_ascii (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2d_in_if.sink    in_i,
  i2d_out_if.source out_o
);
  import i2d_pkg::*;

  // Stage 0: magnitude and sign of the incoming value.
  logic              valid0_q;
  i2d_dab_t          stage0_q;
  logic [ValueW-1:0] bits;
  logic [ValueW-1:0] mag;

  // Handshake and payload between stages; index k feeds dabble stage k+1, the last the serializer.
  logic     valid_s [NumDabStages+1];
  logic     ready_s [NumDabStages+1];
  i2d_dab_t data_s  [NumDabStages+1];

  assign bits = in_i.value;
  // Unsigned negation keeps the most negative value intact.
  assign mag  = bits[ValueW-1] ? (~bits + 1'b1) : bits;

  // Hold stage 0 while the first dabble stage is stalled.
  assign in_i.ready = !valid0_q || ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (in_i.ready) begin
      valid0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      stage0_q.neg <= bits[ValueW-1];
      stage0_q.bcd <= '0;
      stage0_q.bin <= mag;
    end
  end

  assign valid_s[0] = valid0_q;
  assign data_s[0]  = stage0_q;

  // Stages 1 to 4: eight double-dabble steps per stage, 32 in all.
  for (genvar k = 0; k < NumDabStages; k++) begin : g_dab
    i2d_dab_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  // Final stage: emit the sign and the significant digits one by one.
  i2d_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NumDabStages]),
    .ready_o (ready_s[NumDabStages]),
    .data_i  (data_s[NumDabStages]),
    .out_o   (out_o)
  );
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import i2d_pkg::*;

  localparam int unsigned Radix       = 10;
  localparam int unsigned RandomReqs  = 220;
  localparam int unsigned LongHoldOff = 400;

  // One character of decimal text as it should leave the block.
  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } text_char_t;

  // One request waiting to be offered: its value, the idle cycles that follow
  // its acceptance, and whether the sender must first see all text drained.
  typedef struct {
    logic signed [ValueW-1:0] value;
    int unsigned              gap;
    bit                       drain;
  } pending_req_t;

  logic clk;
  logic rst_n;

  // Keep every block input at a known level from time zero.
  logic                     req_valid = 1'b0;
  logic signed [ValueW-1:0] req_value = '0;
  logic                     rsp_ready = 1'b0;
  logic                     req_taken = 1'b0;

  pending_req_t pending_q[$];
  text_char_t   expected_text_q[$];

  int unsigned idle_left    = 0;
  int unsigned hold_left    = 0;
  int unsigned req_count    = 0;
  int unsigned mismatches   = 0;
  bit          long_hold_done = 1'b0;

  i2d_in_if  in_if ();
  i2d_out_if out_if ();

  assign in_if.valid  = req_valid;
  assign in_if.value  = req_value;
  assign out_if.ready = rsp_ready;

  signed_int_to_decimal_ascii u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset low, then release it away from the sampling edge.
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Expected text of one value: an optional minus sign, then the digits of
  // the magnitude, most significant first, with last on the final digit.
  // The magnitude is taken as unsigned so the most negative value survives.
  task automatic append_decimal_text(input logic signed [ValueW-1:0] value);
    logic [ValueW-1:0] magnitude;
    logic [DigitW-1:0] digits [NumDigits];
    int                count;
    text_char_t        ch;
    magnitude = value[ValueW-1] ? ~value + 1'b1 : value;
    count = 0;
    do begin
      digits[count] = DigitW'(magnitude % Radix);
      magnitude     = magnitude / Radix;
      count++;
    end while (magnitude != 0);
    if (value[ValueW-1]) begin
      ch.character = AsciiMinus;
      ch.last      = 1'b0;
      expected_text_q.push_back(ch);
    end
    for (int k = count - 1; k >= 0; k--) begin
      ch.character = AsciiZero + CharW'(digits[k]);
      ch.last      = (k == 0);
      expected_text_q.push_back(ch);
    end
  endtask

  task automatic add_request(input logic signed [ValueW-1:0] value,
                             input int unsigned gap, input bit drain);
    pending_req_t r;
    r.value = value;
    r.gap   = gap;
    r.drain = drain;
    pending_q.push_back(r);
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Spread values over every text length rather than letting full-range
  // random values crowd into ten digits.
  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned    r;
    int unsigned    ndigits;
    longint         mag;
    longint         pow10;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom();
    if (r < 70) begin
      ndigits = $urandom_range(1, NumDigits);
      pow10 = 1;
      for (int i = 0; i < ndigits; i++) pow10 = pow10 * Radix;
      if (ndigits == NumDigits) mag = $urandom_range(1000000000, 2147483647);
      else mag = longint'($urandom()) % pow10;
    end else if (r < 85) begin
      // Land on or beside a power of ten, where the digit count changes.
      pow10 = 1;
      ndigits = $urandom_range(0, NumDigits - 1);
      for (int i = 0; i < ndigits; i++) pow10 = pow10 * Radix;
      mag = pow10 + longint'($urandom_range(0, 2)) - 1;
    end else begin
      mag = $urandom_range(0, 20);
    end
    return $urandom_range(0, 1) ? -ValueW'(mag) : ValueW'(mag);
  endfunction

  // Stimulus and end of run.
  initial begin
    // Directed: zero, single digits, the shortest and longest power-of-ten
    // boundaries, both ends of the range including the most negative value,
    // and alternating bit patterns.
    add_request(0, 0, 1'b0);
    add_request(1, 0, 1'b0);
    add_request(-1, 0, 1'b0);
    add_request(9, 0, 1'b0);
    add_request(-9, 0, 1'b0);
    add_request(10, 0, 1'b0);
    add_request(-10, 0, 1'b0);
    add_request(99, 1, 1'b0);
    add_request(100, 0, 1'b0);
    add_request(2147483647, 0, 1'b0);
    add_request(32'sh8000_0000, 0, 1'b0);
    add_request(-2147483647, 2, 1'b0);
    add_request(1000000000, 0, 1'b0);
    add_request(999999999, 0, 1'b0);
    add_request(-1000000000, 0, 1'b0);
    add_request(-999999999, 0, 1'b0);
    add_request(32'sh5555_5555, 0, 1'b0);
    add_request(32'shAAAA_AAAA, 0, 1'b0);
    add_request(123456789, 0, 1'b0);
    add_request(-123456789, 0, 1'b0);

    // Random: drain fully now and then; keep the sender busy without gaps
    // across the receiver's long hold-off and its calm window.
    for (int i = 0; i < RandomReqs; i++) begin
      add_request(pick_value(),
                  ((i >= 30 && i <= 80) || (i >= 100 && i <= 145)) ? 0 : pick_gap(),
                  (i == 0) || (i % 40 == 20));
    end

    wait (rst_n === 1'b1);
    while (pending_q.size() != 0 || req_valid) @(posedge clk);
    while (expected_text_q.size() != 0) @(posedge clk);
    // Watch a little longer for stray characters.
    repeat (20) @(posedge clk);

    if (expected_text_q.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

  // Request driver: hold a request until taken, then idle for its gap,
  // wait for a full drain where asked, and offer the next one.
  always @(negedge clk) begin : drive_requests
    pending_req_t next_req;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold the current request
    end else if (idle_left != 0) begin
      idle_left = idle_left - 1;
      req_valid <= 1'b0;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].drain && expected_text_q.size() != 0)) begin
      req_valid <= 1'b0;
    end else begin
      next_req  = pending_q.pop_front();
      req_value <= next_req.value;
      req_valid <= 1'b1;
      idle_left = next_req.gap;
    end
  end

  // Receiver: random short and long stalls, one very long hold-off once the
  // pipeline has been running for a while, and a window with no stalls.
  always @(negedge clk) begin : drive_ready
    int unsigned r;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (!long_hold_done && req_count >= 60) begin
      long_hold_done = 1'b1;
      hold_left = LongHoldOff;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (req_count >= 120 && req_count < 165) begin
      rsp_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        rsp_ready <= 1'b1;
      end else begin
        hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 29);
        rsp_ready <= 1'b0;
      end
    end
  end

  // Sample both handshakes at the rising edge: predict text for every
  // accepted request and check every accepted character against the oldest
  // expectation.
  always @(posedge clk) begin : watch_ports
    text_char_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        append_decimal_text(in_if.value);
        req_count++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_text_q.size() == 0) begin
          $error("unexpected character %h (last %b)", out_if.character, out_if.last);
          mismatches++;
        end else begin
          want = expected_text_q.pop_front();
          if (out_if.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_if.character);
            mismatches++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_if.last);
            mismatches++;
          end
        end
      end
    end
    req_taken <= rst_n && in_if.valid && in_if.ready;
  end

  // Drop the run if it hangs.
  initial begin
    #5_000_000;
    $display("[signed_int_to_decimal_ascii] ERROR");
    $finish;
  end

endmodule
